// ===== src/bxpd_pkg.sv =====
// ----------------------------------------------------------------------------
// bxpd_pkg
// Types, constants and helper functions shared by the binary XNOR/popcount
// dot product core and its stages.
// ----------------------------------------------------------------------------
package bxpd_pkg;

    localparam int WORD_W    = 64;
    localparam int MAX_LANES = 4;
    localparam int NIBBLE_W  = 4;
    localparam logic [NIBBLE_W-1:0] NIBBLE_MASK = 4'hf;

    localparam int CFG_IDX_W = 4;
    localparam int CFG_W     = 16;
    localparam int TOTAL_W   = 16;
    localparam int SLOPE_W   = 16;
    localparam int COUNT_W   = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // total_bits - 2 * count spans [-2 * COUNT_MAX, 2**TOTAL_W - 1]
    localparam int D_W   = COUNT_W + 2;
    localparam int ACT_W = 33;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOTAL_BITS  = 4'd0,
        CFG_PRELU_SLOPE = 4'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [WORD_W-1:0] act_word0;
        logic [WORD_W-1:0] act_word1;
        logic [WORD_W-1:0] act_word2;
        logic [WORD_W-1:0] act_word3;
        logic [WORD_W-1:0] wgt_word0;
        logic [WORD_W-1:0] wgt_word1;
        logic [WORD_W-1:0] wgt_word2;
        logic [WORD_W-1:0] wgt_word3;
        logic              last_chunk;
    } t_req;

    typedef struct packed {
        logic signed [ACT_W-1:0] activation;
        logic                    count_saturated;
    } t_rsp;

    function automatic logic [2:0] nibble_ones(input logic [NIBBLE_W-1:0] nib);
        logic [2:0] n;
        case (nib & NIBBLE_MASK)
            4'h0:                      n = 3'd0;
            4'h1, 4'h2, 4'h4, 4'h8:    n = 3'd1;
            4'h3, 4'h5, 4'h6, 4'h9,
            4'ha, 4'hc:                n = 3'd2;
            4'h7, 4'hb, 4'hd, 4'he:    n = 3'd3;
            default:                   n = 3'd4;
        endcase
        return n;
    endfunction

    // Mismatch bits of one lane: activation XOR weight
    function automatic logic [WORD_W-1:0] lane_xor(input t_req req, input logic [1:0] lane);
        logic [WORD_W-1:0] w;
        case (lane)
            2'd0:    w = req.act_word0 ^ req.wgt_word0;
            2'd1:    w = req.act_word1 ^ req.wgt_word1;
            2'd2:    w = req.act_word2 ^ req.wgt_word2;
            default: w = req.act_word3 ^ req.wgt_word3;
        endcase
        return w;
    endfunction

endpackage

// ===== src/binary_xnor_popcount_dot_prelu_core.sv =====
// ----------------------------------------------------------------------------
// binary_xnor_popcount_dot_prelu_core
// Binary dot product by XOR and popcount with a fixed-point PReLU result.
// ----------------------------------------------------------------------------
// Takes one request of LANES packed 64-bit activation/weight word pairs per
// clock while o_stall is low and answers with one result on each request
// marked last_chunk. The path is four registers deep: input register,
// popcount tree, saturating accumulator (which also forms total_bits - 2 *
// count) and the PReLU result register. The accumulator is the only loop, so
// the block sustains one request per cycle when nothing stalls. o_stall
// comes from a one-entry skid register in front of the input register, and
// the result register holds under i_stall while the skid takes one more
// request. The user must write configuration only while no product is in
// flight; the block does not enforce this. o_cfg_ready is always high and
// writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module binary_xnor_popcount_dot_prelu_core #(
    parameter int LANES           = 4,
    parameter int SLOPE_FRAC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  bxpd_pkg::t_req                    i_req,
    output logic                              o_stall,
    output logic                              o_valid,
    output bxpd_pkg::t_rsp                    o_rsp,
    input  logic                              i_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [bxpd_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bxpd_pkg::CFG_W-1:0]        i_cfg_data
);
    import bxpd_pkg::*;

    localparam int SUM_W = $clog2(LANES * WORD_W + 1);

    logic [TOTAL_W-1:0]       r_total_bits;
    logic signed [SLOPE_W-1:0] r_prelu_slope;

    logic                     w_en;
    logic                     w_head_valid;
    t_req                     w_head_req;
    logic                     w_pc_valid;
    logic                     w_pc_last;
    logic [SUM_W-1:0]         w_pc_sum;
    logic                     w_acc_valid;
    logic signed [D_W-1:0]    w_acc_d;
    logic                     w_acc_sat;
    logic                     w_out_valid;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total_bits  <= '0;
            r_prelu_slope <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_TOTAL_BITS:  r_total_bits  <= i_cfg_data[TOTAL_W-1:0];
                CFG_PRELU_SLOPE: r_prelu_slope <= $signed(i_cfg_data[SLOPE_W-1:0]);
                default: ;
            endcase
        end
    end

    // advance the whole pipeline unless a finished result is held
    assign w_en    = !w_out_valid || !i_stall;
    assign o_valid = w_out_valid;

    bxpd_in_skid u_in_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_stall (o_stall),
        .i_en    (w_en),
        .o_valid (w_head_valid),
        .o_req   (w_head_req)
    );

    bxpd_popcount #(
        .LANES (LANES),
        .SUM_W (SUM_W)
    ) u_popcount (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_head_valid),
        .i_req   (w_head_req),
        .o_valid (w_pc_valid),
        .o_last  (w_pc_last),
        .o_sum   (w_pc_sum)
    );

    bxpd_accum #(
        .SUM_W (SUM_W)
    ) u_accum (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_valid      (w_pc_valid),
        .i_last       (w_pc_last),
        .i_sum        (w_pc_sum),
        .i_total_bits (r_total_bits),
        .o_valid      (w_acc_valid),
        .o_d          (w_acc_d),
        .o_sat        (w_acc_sat)
    );

    bxpd_prelu #(
        .SLOPE_FRAC_BITS (SLOPE_FRAC_BITS)
    ) u_prelu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_acc_valid),
        .i_d     (w_acc_d),
        .i_sat   (w_acc_sat),
        .i_slope (r_prelu_slope),
        .o_valid (w_out_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== src/bxpd_in_skid.sv =====
// ----------------------------------------------------------------------------
// bxpd_in_skid
// Input register with one skid entry, so the upstream stall is a register.
// ----------------------------------------------------------------------------
module bxpd_in_skid (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  bxpd_pkg::t_req i_req,
    output logic          o_stall,
    input  logic          i_en,
    output logic          o_valid,
    output bxpd_pkg::t_req o_req
);
    import bxpd_pkg::*;

    logic r_in_valid;
    logic r_skid_valid;
    t_req r_in_req;
    t_req r_skid_req;
    logic w_accept;

    assign o_stall  = r_skid_valid;
    assign w_accept = i_valid && !r_skid_valid;
    assign o_valid  = r_in_valid;
    assign o_req    = r_in_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_en) begin
            if (r_skid_valid) begin
                r_in_valid   <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_in_valid <= w_accept;
            end
        end else if (w_accept) begin
            if (r_in_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_in_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_in_req <= r_skid_valid ? r_skid_req : i_req;
        end else if (w_accept && !r_in_valid) begin
            r_in_req <= i_req;
        end
        if (!i_en && w_accept && r_in_valid) begin
            r_skid_req <= i_req;
        end
    end

    a_skid_behind_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_in_valid)
        else $error("skid entry held without a head request");

    a_skid_fill_on_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(!i_en))
        else $error("skid entry filled while the pipeline advanced");

endmodule

// ===== src/bxpd_popcount.sv =====
// ----------------------------------------------------------------------------
// bxpd_popcount
// XOR of each lane pair and a registered nibble-table adder tree over all
// active lanes.
// ----------------------------------------------------------------------------
module bxpd_popcount #(
    parameter int LANES = 4,
    parameter int SUM_W = 9
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  bxpd_pkg::t_req   i_req,
    output logic             o_valid,
    output logic             o_last,
    output logic [SUM_W-1:0] o_sum
);
    import bxpd_pkg::*;

    localparam int NIBS   = WORD_W / NIBBLE_W;
    localparam int LEAVES = MAX_LANES * NIBS;
    localparam int LEVELS = $clog2(LEAVES);

    logic [SUM_W-1:0] w_node [LEVELS+1][LEAVES];
    logic             r_valid;
    logic             r_last;
    logic [SUM_W-1:0] r_sum;

    always_comb begin
        logic [WORD_W-1:0] lane_word;
        for (int l = 0; l <= LEVELS; l++) begin
            for (int i = 0; i < LEAVES; i++) begin
                w_node[l][i] = '0;
            end
        end
        // leaves: ones per nibble, inactive lanes stay zero
        for (int lane = 0; lane < MAX_LANES; lane++) begin
            lane_word = lane_xor(i_req, 2'(lane));
            for (int k = 0; k < NIBS; k++) begin
                if (lane < LANES) begin
                    w_node[0][lane*NIBS+k] = SUM_W'(nibble_ones(lane_word[k*NIBBLE_W +: NIBBLE_W]));
                end
            end
        end
        for (int l = 1; l <= LEVELS; l++) begin
            for (int i = 0; i < (LEAVES >> l); i++) begin
                w_node[l][i] = w_node[l-1][2*i] + w_node[l-1][2*i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_last <= i_req.last_chunk;
            r_sum  <= w_node[LEVELS][0];
        end
    end

    assign o_valid = r_valid;
    assign o_last  = r_last;
    assign o_sum   = r_sum;

endmodule

// ===== src/bxpd_accum.sv =====
// ----------------------------------------------------------------------------
// bxpd_accum
// Saturating mismatch accumulator; on the last request forms
// total_bits - 2 * count and clears the running state.
// ----------------------------------------------------------------------------
module bxpd_accum #(
    parameter int SUM_W = 9
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic                          i_last,
    input  logic [SUM_W-1:0]              i_sum,
    input  logic [bxpd_pkg::TOTAL_W-1:0]  i_total_bits,
    output logic                          o_valid,
    output logic signed [bxpd_pkg::D_W-1:0] o_d,
    output logic                          o_sat
);
    import bxpd_pkg::*;

    logic [COUNT_W-1:0]    r_count;
    logic                  r_sat;
    logic                  r_valid;
    logic signed [D_W-1:0] r_d;
    logic                  r_out_sat;

    logic [COUNT_W:0]      w_sum;
    logic                  w_ovf;
    logic [COUNT_W-1:0]    n_count;
    logic signed [D_W-1:0] n_d;

    always_comb begin
        w_sum   = {1'b0, r_count} + (COUNT_W+1)'(i_sum);
        w_ovf   = w_sum[COUNT_W];
        n_count = w_ovf ? COUNT_MAX : w_sum[COUNT_W-1:0];
        n_d     = $signed(D_W'(i_total_bits)) - $signed({1'b0, n_count, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sat   <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid && i_last;
            if (i_valid) begin
                // clear after the product ends
                if (i_last) begin
                    r_count <= '0;
                    r_sat   <= 1'b0;
                end else begin
                    r_count <= n_count;
                    r_sat   <= r_sat || w_ovf;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d       <= n_d;
            r_out_sat <= r_sat || w_ovf;
        end
    end

    assign o_valid = r_valid;
    assign o_d     = r_d;
    assign o_sat   = r_out_sat;

    a_sat_pins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sat |-> (r_count == COUNT_MAX))
        else $error("saturation flag set with count below maximum");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && i_valid && i_last) |=> (r_count == '0 && !r_sat))
        else $error("running count not cleared after last request");

endmodule

// ===== src/bxpd_prelu.sv =====
// ----------------------------------------------------------------------------
// bxpd_prelu
// PReLU on the dot product: shift for non-negative, slope multiply for
// negative, clamp to the output width, then the result register.
// ----------------------------------------------------------------------------
module bxpd_prelu #(
    parameter int SLOPE_FRAC_BITS = 12
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [bxpd_pkg::D_W-1:0]   i_d,
    input  logic                              i_sat,
    input  logic signed [bxpd_pkg::SLOPE_W-1:0] i_slope,
    output logic                              o_valid,
    output bxpd_pkg::t_rsp                    o_rsp
);
    import bxpd_pkg::*;

    localparam int PROD_W = D_W + ((SLOPE_FRAC_BITS > SLOPE_W) ? SLOPE_FRAC_BITS : SLOPE_W);

    logic signed [PROD_W-1:0] w_d_ext;
    logic signed [PROD_W-1:0] w_slope_ext;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] w_shl;
    logic signed [PROD_W-1:0] w_act;
    logic [PROD_W-ACT_W:0]    w_hi;
    logic signed [ACT_W-1:0]  n_act;
    logic                     r_valid;
    t_rsp                     r_rsp;

    always_comb begin
        w_d_ext     = PROD_W'(i_d);
        w_slope_ext = PROD_W'(i_slope);
        w_prod      = w_d_ext * w_slope_ext;
        w_shl       = w_d_ext <<< SLOPE_FRAC_BITS;
        w_act       = i_d[D_W-1] ? w_prod : w_shl;
        w_hi        = w_act[PROD_W-1:ACT_W-1];
        // clamp when the upper bits are not a sign extension
        if ((&w_hi) || !(|w_hi)) begin
            n_act = w_act[ACT_W-1:0];
        end else if (w_act[PROD_W-1]) begin
            n_act = {1'b1, {(ACT_W-1){1'b0}}};
        end else begin
            n_act = {1'b0, {(ACT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rsp.activation      <= n_act;
            r_rsp.count_saturated <= i_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule
